@@ hw/rtl/rfpp_pkg.sv @@
// Shared types, constants and helpers of the rectangle fill and pixel pack block.
package rfpp_pkg;

  localparam int unsigned CoordBits  = 12;
  localparam int unsigned ColourBits = 32;
  localparam int unsigned FmtBits    = 5;
  localparam int unsigned StrideBits = 14;
  localparam int unsigned OffsetBits = 26;
  localparam int unsigned CountBits  = 3;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits    = 14;

  localparam logic [FmtBits-1:0]    FormatReset = FmtBits'(3);
  localparam logic [StrideBits-1:0] StrideReset = '0;
  localparam logic [CoordBits-1:0]  WidthReset  = CoordBits'(720);
  localparam logic [CoordBits-1:0]  HeightReset = CoordBits'(576);

  typedef enum logic [FmtBits-1:0] {
    FmtRgba32 = 5'd0,
    FmtRgb24  = 5'd1,
    Fmt655    = 5'd2,
    Fmt565    = 5'd3,
    Fmt6442   = 5'd4,
    Fmt844    = 5'd5,
    Fmt4444R  = 5'd6,
    Fmt4642R  = 5'd7,
    Fmt1555A  = 5'd8,
    Fmt4444A  = 5'd9,
    Fmt6666A  = 5'd10,
    Fmt6666R  = 5'd11,
    Fmt8565   = 5'd12,
    Fmt5658   = 5'd13,
    Fmt888B   = 5'd14,
    FmtBgra   = 5'd15,
    FmtAbgr   = 5'd16,
    FmtArgb   = 5'd17
  } rfpp_format_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegFormat = 2'd0,
    RegStride = 2'd1,
    RegWidth  = 2'd2,
    RegHeight = 2'd3
  } rfpp_reg_e;

  typedef enum logic {
    ModeStart = 1'b0,
    ModeStep  = 1'b1
  } rfpp_mode_e;

  typedef struct packed {
    logic                  mode;
    logic [ColourBits-1:0] argb_colour;
    logic [CoordBits-1:0]  corner_ax;
    logic [CoordBits-1:0]  corner_ay;
    logic [CoordBits-1:0]  corner_bx;
    logic [CoordBits-1:0]  corner_by;
  } rfpp_in_t;

  typedef struct packed {
    logic [OffsetBits-1:0] byte_offset;
    logic [ColourBits-1:0] pixel_bits;
    logic [CountBits-1:0]  byte_count;
    logic                  last_pixel;
  } rfpp_out_t;

  // Bytes per pixel; unknown codes fall back to 4.
  function automatic logic [CountBits-1:0] fmt_bytes(logic [FmtBits-1:0] fmt);
    logic [CountBits-1:0] n;
    case (fmt) inside
      [Fmt655:Fmt4444A]:           n = CountBits'(2);
      FmtRgb24, [Fmt6666A:Fmt888B]: n = CountBits'(3);
      default:                     n = CountBits'(4);
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/rfpp_pack.sv @@
// Packs a 32-bit ARGB colour into the selected pixel format.
module rfpp_pack (
  input  logic [rfpp_pkg::FmtBits-1:0]    fmt_i,
  input  logic [rfpp_pkg::ColourBits-1:0] argb_i,
  output logic [rfpp_pkg::ColourBits-1:0] pixel_o
);
  import rfpp_pkg::*;

  logic [7:0] a, r, g, b;

  assign a = argb_i[31:24];
  assign r = argb_i[23:16];
  assign g = argb_i[15:8];
  assign b = argb_i[7:0];

  always_comb begin
    case (fmt_i)
      FmtRgba32: pixel_o = {r, g, b, a};
      FmtRgb24:  pixel_o = {8'h00, r, g, b};
      Fmt655:    pixel_o = {16'h0000, r[7:2], g[7:3], b[7:3]};
      Fmt565:    pixel_o = {16'h0000, r[7:3], g[7:2], b[7:3]};
      Fmt6442:   pixel_o = {16'h0000, r[7:2], g[7:4], b[7:4], a[7:6]};
      Fmt844:    pixel_o = {16'h0000, r, g[7:4], b[7:4]};
      Fmt4444R:  pixel_o = {16'h0000, r[7:4], g[7:4], b[7:4], a[7:4]};
      Fmt4642R:  pixel_o = {16'h0000, r[7:4], g[7:2], b[7:4], a[7:6]};
      Fmt1555A:  pixel_o = {16'h0000, a[7], r[7:3], g[7:3], b[7:3]};
      Fmt4444A:  pixel_o = {16'h0000, a[7:4], r[7:4], g[7:4], b[7:4]};
      Fmt6666A:  pixel_o = {8'h00, a[7:2], r[7:2], g[7:2], b[7:2]};
      Fmt6666R:  pixel_o = {8'h00, r[7:2], g[7:2], b[7:2], a[7:2]};
      Fmt8565:   pixel_o = {8'h00, a, r[7:3], g[7:2], b[7:3]};
      Fmt5658:   pixel_o = {8'h00, r[7:3], g[7:2], b[7:3], a};
      Fmt888B:   pixel_o = {8'h00, b, g, r};
      FmtBgra:   pixel_o = {b, g, r, a};
      FmtAbgr:   pixel_o = {a, b, g, r};
      default:   pixel_o = {a, r, g, b};
    endcase
  end

endmodule

@@ hw/rtl/rect_fill_pixel_pack_core.sv @@
// Rectangle fill engine: packs a colour once per fill and emits one pixel write per step
// word during a fill. Throughput is one word per cycle: a start word loads the fill state
// and never yields a result; each step word of a fill yields one pixel write in the next
// cycle through the output register (offset = y*stride + x*bytes, one 12x14 multiply and
// an add). The input stalls only while that output register is full and stalled.
// Corners are checked against screen_width/screen_height (inclusive), sorted, and the
// larger corner is exclusive; an empty or rejected rectangle writes nothing.
module rect_fill_pixel_pack_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rfpp_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [rfpp_pkg::CfgBits-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rfpp_pkg::rfpp_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rfpp_pkg::rfpp_out_t             out_data_o
);
  import rfpp_pkg::*;

  logic [FmtBits-1:0]    fmt_q;
  logic [StrideBits-1:0] stride_q;
  logic [CoordBits-1:0]  scr_w_q, scr_h_q;

  logic                  active_q, active_d;
  logic [ColourBits-1:0] colour_q, colour_d;
  logic [CoordBits-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CoordBits-1:0]  start_x_q, start_x_d, end_x_q, end_x_d, end_y_q, end_y_d;
  logic                  out_valid_q, out_valid_d;
  rfpp_out_t             out_data_q, out_data_d;

  logic                  accept, do_start, do_step, reject;
  logic [CoordBits-1:0]  x0, x1, y0, y1, nx, ny;
  logic [CountBits-1:0]  bytes;
  logic [ColourBits-1:0] packed_colour;
  logic [OffsetBits-1:0] row_off, col_off;
  logic [CoordBits:0]    nx_w, ny_w;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign do_start    = accept && (in_data_i.mode == ModeStart);
  assign do_step     = accept && (in_data_i.mode == ModeStep) && active_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FormatReset;
      stride_q <= StrideReset;
      scr_w_q  <= WidthReset;
      scr_h_q  <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFormat: fmt_q    <= cfg_wdata_i[FmtBits-1:0];
        RegStride: stride_q <= cfg_wdata_i[StrideBits-1:0];
        RegWidth:  scr_w_q  <= cfg_wdata_i[CoordBits-1:0];
        RegHeight: scr_h_q  <= cfg_wdata_i[CoordBits-1:0];
        default:   ;
      endcase
    end
  end

  rfpp_pack u_pack (
    .fmt_i   (fmt_q),
    .argb_i  (in_data_i.argb_colour),
    .pixel_o (packed_colour)
  );

  // start: bounds check and corner sort
  always_comb begin
    reject = (in_data_i.corner_ax > scr_w_q) || (in_data_i.corner_bx > scr_w_q) ||
             (in_data_i.corner_ay > scr_h_q) || (in_data_i.corner_by > scr_h_q) ||
             (fmt_q > FmtArgb);
    if (in_data_i.corner_ax > in_data_i.corner_bx) begin
      x0 = in_data_i.corner_bx;
      x1 = in_data_i.corner_ax;
    end else begin
      x0 = in_data_i.corner_ax;
      x1 = in_data_i.corner_bx;
    end
    if (in_data_i.corner_ay > in_data_i.corner_by) begin
      y0 = in_data_i.corner_by;
      y1 = in_data_i.corner_ay;
    end else begin
      y0 = in_data_i.corner_ay;
      y1 = in_data_i.corner_by;
    end
  end

  // step: address and cursor advance
  assign bytes   = fmt_bytes(fmt_q);
  assign row_off = OffsetBits'(cur_y_q * stride_q);
  assign col_off = OffsetBits'(cur_x_q * bytes);
  assign nx_w    = {1'b0, cur_x_q} + 1'b1;
  assign ny_w    = {1'b0, cur_y_q} + 1'b1;
  assign nx      = nx_w[CoordBits-1:0];
  assign ny      = ny_w[CoordBits-1:0];

  always_comb begin
    active_d   = active_q;
    colour_d   = colour_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    start_x_d  = start_x_q;
    end_x_d    = end_x_q;
    end_y_d    = end_y_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (do_start) begin
      active_d = 1'b0;
      if (!reject) begin
        colour_d  = packed_colour;
        cur_x_d   = x0;
        cur_y_d   = y0;
        start_x_d = x0;
        end_x_d   = x1;
        end_y_d   = y1;
        active_d  = (x0 != x1) && (y0 != y1);
      end
    end else if (do_step) begin
      out_valid_d            = 1'b1;
      out_data_d.byte_offset = row_off + col_off;
      out_data_d.pixel_bits  = colour_q;
      out_data_d.byte_count  = bytes;
      out_data_d.last_pixel  = (nx_w == {1'b0, end_x_q}) && (ny_w == {1'b0, end_y_q});
      cur_x_d = nx;
      if (nx == end_x_q) begin
        cur_x_d = start_x_q;
        cur_y_d = ny;
        if (ny == end_y_q) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      colour_q    <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      start_x_q   <= '0;
      end_x_q     <= '0;
      end_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      colour_q    <= colour_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      start_x_q   <= start_x_d;
      end_x_q     <= end_x_d;
      end_y_q     <= end_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

@@ hw/rtl/rfpp_checker.sv @@
// Port-level checks for the rectangle fill core, bound to the top level.
module rfpp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input rfpp_pkg::rfpp_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rfpp_pkg::rfpp_out_t out_data_o
);
  import rfpp_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // input backs up only behind a full, stalled output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a start word never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.mode == ModeStart) &&
    !(out_valid_o && out_stall_i) |=> !out_valid_o)
    else $error("result after start word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.byte_count >= CountBits'(2)) &&
                    (out_data_o.byte_count <= CountBits'(4)))
    else $error("byte count out of range");

endmodule

bind rect_fill_pixel_pack_core rfpp_checker u_rfpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ dv/tb.sv @@
// Self-checking testbench for rect_fill_pixel_pack_core against a pixel-write predictor.
`timescale 1ns / 1ps

module tb;
  import rfpp_pkg::*;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i   = '0;
  logic [CfgBits-1:0]    cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  rfpp_in_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rfpp_out_t             out_data_o;

  rect_fill_pixel_pack_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Register copies and fill state of the predictor.
  logic [FmtBits-1:0] fmt_r    = FormatReset;
  int unsigned        stride_r = 0;
  int unsigned        scr_w    = 720;
  int unsigned        scr_h    = 576;

  logic        fill_on  = 1'b0;
  logic [31:0] colour_q = '0;
  int unsigned cur_x    = 0;
  int unsigned cur_y    = 0;
  int unsigned row_x0   = 0;
  int unsigned row_x1   = 0;
  int unsigned end_y    = 0;

  rfpp_in_t  word_q[$];
  rfpp_out_t exp_pixels[$];
  rfpp_out_t want_px;

  int unsigned mismatches  = 0;
  int unsigned pixels_seen = 0;
  int unsigned burst_left  = 8;
  int unsigned gap_left    = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;
  int unsigned stall_mode  = 0;
  int unsigned mode_left   = 0;

  function automatic logic [31:0] pack_argb(logic [FmtBits-1:0] fmt, logic [31:0] argb);
    logic [31:0] a, r, g, b, p;
    a = {24'd0, argb[31:24]};
    r = {24'd0, argb[23:16]};
    g = {24'd0, argb[15:8]};
    b = {24'd0, argb[7:0]};
    case (fmt)
      FmtRgba32: p = a | (b << 8) | (g << 16) | (r << 24);
      FmtRgb24:  p = (r << 16) | (g << 8) | b;
      Fmt655:    p = (b >> 3) | ((g >> 3) << 5) | ((r >> 2) << 10);
      Fmt565:    p = (b >> 3) | ((g >> 2) << 5) | ((r >> 3) << 11);
      Fmt6442:   p = (a >> 6) | ((b >> 4) << 2) | ((g >> 4) << 6) | ((r >> 2) << 10);
      Fmt844:    p = (b >> 4) | ((g >> 4) << 4) | (r << 8);
      Fmt4444R:  p = (a >> 4) | ((b >> 4) << 4) | ((g >> 4) << 8) | ((r >> 4) << 12);
      Fmt4642R:  p = (a >> 6) | ((b >> 4) << 2) | ((g >> 2) << 6) | ((r >> 4) << 12);
      Fmt1555A:  p = ((a >> 7) << 15) | (b >> 3) | ((g >> 3) << 5) | ((r >> 3) << 10);
      Fmt4444A:  p = ((a >> 4) << 12) | (b >> 4) | ((g >> 4) << 4) | ((r >> 4) << 8);
      Fmt6666A:  p = ((a >> 2) << 18) | (b >> 2) | ((g >> 2) << 6) | ((r >> 2) << 12);
      Fmt6666R:  p = (a >> 2) | ((b >> 2) << 6) | ((g >> 2) << 12) | ((r >> 2) << 18);
      Fmt8565:   p = (a << 16) | (b >> 3) | ((g >> 2) << 5) | ((r >> 3) << 11);
      Fmt5658:   p = a | ((b >> 3) << 8) | ((g >> 2) << 13) | ((r >> 3) << 19);
      Fmt888B:   p = (b << 16) | (g << 8) | r;
      FmtBgra:   p = a | (b << 24) | (g << 16) | (r << 8);
      FmtAbgr:   p = (a << 24) | (b << 16) | (g << 8) | r;
      default:   p = (a << 24) | b | (g << 8) | (r << 16);
    endcase
    return p;
  endfunction

  // Unknown format codes write 4 bytes.
  function automatic int unsigned bytes_per_pixel(logic [FmtBits-1:0] fmt);
    int unsigned n;
    n = 4;
    if (fmt >= Fmt655 && fmt <= Fmt4444A) n = 2;
    else if (fmt == FmtRgb24 || (fmt >= Fmt6666A && fmt <= Fmt888B)) n = 3;
    return n;
  endfunction

  task automatic advance_fill_model(rfpp_in_t w);
    int unsigned     x0, y0, x1, y1, t, nbytes;
    longint unsigned off;
    rfpp_out_t       px;
    x0 = 32'(w.corner_ax);
    y0 = 32'(w.corner_ay);
    x1 = 32'(w.corner_bx);
    y1 = 32'(w.corner_by);
    if (w.mode == ModeStart) begin
      // a start always ends the running fill, accepted or not
      fill_on = 1'b0;
      if (x0 <= scr_w && x1 <= scr_w && y0 <= scr_h && y1 <= scr_h && fmt_r <= FmtArgb) begin
        if (x0 > x1) begin
          t = x0; x0 = x1; x1 = t;
        end
        if (y0 > y1) begin
          t = y0; y0 = y1; y1 = t;
        end
        colour_q = pack_argb(fmt_r, w.argb_colour);
        cur_x    = x0;
        cur_y    = y0;
        row_x0   = x0;
        row_x1   = x1;
        end_y    = y1;
        fill_on  = (x0 != x1) && (y0 != y1);
      end
    end else if (fill_on) begin
      nbytes = bytes_per_pixel(fmt_r);
      off = longint'(cur_y) * longint'(stride_r) + longint'(cur_x) * longint'(nbytes);
      px.byte_offset = off[OffsetBits-1:0];
      px.pixel_bits  = colour_q;
      px.byte_count  = nbytes[CountBits-1:0];
      px.last_pixel  = (cur_x + 1 == row_x1) && (cur_y + 1 == end_y);
      exp_pixels.push_back(px);
      cur_x = (cur_x + 1) % 4096;
      if (cur_x == row_x1) begin
        cur_x = row_x0;
        cur_y = (cur_y + 1) % 4096;
        if (cur_y == end_y) fill_on = 1'b0;
      end
    end
  endtask

  // Driver: bursts of words with random gaps; a stalled word is held.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) advance_fill_model(in_data_i);
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          gap_left   = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (word_q.size() != 0) begin
          in_data_i  <= word_q.pop_front();
          in_valid_i <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off once traffic is flowing.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && pixels_seen >= 150) begin
      hold_done   <= 1'b1;
      hold_left   <= 400;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(5, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: each accepted word against the oldest expected pixel write.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pixels_seen <= pixels_seen + 1;
      if (exp_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected pixel write: offset %0h data %08h count %0d last %0b",
                   out_data_o.byte_offset, out_data_o.pixel_bits, out_data_o.byte_count,
                   out_data_o.last_pixel);
        mismatches <= mismatches + 1;
      end else begin
        want_px = exp_pixels.pop_front();
        if (out_data_o.byte_offset !== want_px.byte_offset ||
            out_data_o.pixel_bits !== want_px.pixel_bits ||
            out_data_o.byte_count !== want_px.byte_count ||
            out_data_o.last_pixel !== want_px.last_pixel) begin
          if (mismatches < 10)
            $display("pixel mismatch: exp off %0h data %08h cnt %0d last %0b,",
                     want_px.byte_offset, want_px.pixel_bits, want_px.byte_count,
                     want_px.last_pixel,
                     " got off %0h data %08h cnt %0d last %0b",
                     out_data_o.byte_offset, out_data_o.pixel_bits,
                     out_data_o.byte_count, out_data_o.last_pixel);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  task automatic write_reg(rfpp_reg_e idx, logic [CfgBits-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegFormat: fmt_r    = val[FmtBits-1:0];
      RegStride: stride_r = 32'(val);
      RegWidth:  scr_w    = 32'(val[CoordBits-1:0]);
      default:   scr_h    = 32'(val[CoordBits-1:0]);
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [CfgBits-1:0] fmt, logic [CfgBits-1:0] stride,
                           logic [CfgBits-1:0] w, logic [CfgBits-1:0] h);
    write_reg(RegFormat, fmt);
    write_reg(RegStride, stride);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
  endtask

  task automatic push_start(logic [11:0] ax, logic [11:0] ay, logic [11:0] bx,
                            logic [11:0] by, logic [31:0] argb);
    rfpp_in_t w;
    w.mode        = ModeStart;
    w.argb_colour = argb;
    w.corner_ax   = ax;
    w.corner_ay   = ay;
    w.corner_bx   = bx;
    w.corner_by   = by;
    word_q.push_back(w);
  endtask

  // Step words carry random junk in the unused fields.
  task automatic push_steps(int unsigned n);
    rfpp_in_t w;
    repeat (n) begin
      w.mode        = ModeStep;
      w.argb_colour = $urandom();
      w.corner_ax   = CoordBits'($urandom_range(0, 4095));
      w.corner_ay   = CoordBits'($urandom_range(0, 4095));
      w.corner_bx   = CoordBits'($urandom_range(0, 4095));
      w.corner_by   = CoordBits'($urandom_range(0, 4095));
      word_q.push_back(w);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (word_q.size() != 0 || in_valid_i || exp_pixels.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // One start plus steps; mostly small in-screen rectangles run to (or near) completion.
  task automatic queue_random_fill(output int unsigned counted);
    int unsigned x0, y0, x1, y1, t, pick, area, nstep;
    logic [31:0] argb;
    logic        ok;
    pick = $urandom_range(0, 99);
    argb = $urandom();
    if ($urandom_range(0, 9) == 0) argb = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
    if (pick < 75) begin
      x0 = $urandom_range(0, scr_w);
      y0 = $urandom_range(0, scr_h);
      x1 = x0 + $urandom_range(0, 4);
      y1 = y0 + $urandom_range(0, 3);
      if (x1 > scr_w) x1 = scr_w;
      if (y1 > scr_h) y1 = scr_h;
    end else if (pick < 88) begin
      x0 = $urandom_range(0, 4095);
      y0 = $urandom_range(0, 4095);
      x1 = $urandom_range(0, 4095);
      y1 = $urandom_range(0, 4095);
    end else begin
      // on or just past the screen edge
      x0 = (scr_w + $urandom_range(0, 1)) % 4096;
      y0 = (scr_h + $urandom_range(0, 1)) % 4096;
      x1 = $urandom_range(0, scr_w);
      y1 = $urandom_range(0, scr_h);
    end
    if ($urandom_range(0, 1)) begin
      t = x0; x0 = x1; x1 = t;
    end
    if ($urandom_range(0, 1)) begin
      t = y0; y0 = y1; y1 = t;
    end
    push_start(x0[11:0], y0[11:0], x1[11:0], y1[11:0], argb);
    ok = (x0 <= scr_w) && (x1 <= scr_w) && (y0 <= scr_h) && (y1 <= scr_h) &&
         (fmt_r <= FmtArgb);
    area = ((x0 > x1) ? x0 - x1 : x1 - x0) * ((y0 > y1) ? y0 - y1 : y1 - y0);
    if (area > 24) area = 24;
    nstep = ($urandom_range(0, 4) == 0) ? $urandom_range(0, area)
                                        : area + $urandom_range(0, 1);
    push_steps(nstep);
    counted = 1 + (ok ? ((nstep < area) ? nstep : area) : 0);
  endtask

  initial begin
    int unsigned       phase, got, n;
    logic [CfgBits-1:0] fmt, stride, w, h;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values: format 565, stride 0, 720 x 576
    push_steps(1);
    push_start(12'd3, 12'd2, 12'd1, 12'd0, 32'hffff_ffff);
    push_steps(5);
    push_start(12'd721, 12'd0, 12'd0, 12'd1, 32'h1234_5678);
    push_steps(1);
    push_start(12'd0, 12'd577, 12'd1, 12'd1, 32'h1234_5678);
    push_steps(1);
    push_start(12'd5, 12'd5, 12'd5, 12'd9, 32'h8000_0001);
    push_steps(1);
    push_start(12'd720, 12'd576, 12'd719, 12'd575, 32'h0);
    push_steps(1);
    push_start(12'd0, 12'd0, 12'd4, 12'd1, 32'h7f80_01fe);
    push_steps(2);
    push_start(12'd0, 12'd0, 12'd0, 12'd0, 32'h0);
    push_steps(1);
    wait_drained();

    write_all(CfgBits'(FmtArgb), 14'h3fff, 14'd4095, 14'd4095);
    push_start(12'd4095, 12'd4095, 12'd4093, 12'd4093, 32'ha5c3_3c5a);
    push_steps(4);
    push_start(12'd0, 12'd0, 12'd4095, 12'd4095, 32'h0f1e_2d3c);
    push_steps(2);
    wait_drained();
    // unknown format mid-fill: old color, 4 bytes; a new start is refused
    write_reg(RegFormat, 14'd31);
    push_steps(1);
    push_start(12'd0, 12'd0, 12'd1, 12'd1, 32'h5555_aaaa);
    push_steps(1);
    wait_drained();

    for (phase = 0; phase < 22; phase++) begin
      fmt = (phase < 18) ? CfgBits'(phase) : CfgBits'($urandom_range(0, 31));
      case ($urandom_range(0, 3))
        0:       stride = '0;
        1:       stride = 14'h3fff;
        default: stride = CfgBits'($urandom_range(0, 16383));
      endcase
      case ($urandom_range(0, 5))
        0:       w = '0;
        1:       w = 14'd4095;
        2:       w = CfgBits'($urandom_range(1, 8));
        default: w = CfgBits'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 5))
        0:       h = '0;
        1:       h = 14'd4095;
        2:       h = CfgBits'($urandom_range(1, 8));
        default: h = CfgBits'($urandom_range(0, 4095));
      endcase
      write_all(fmt, stride, w, h);
      got = 0;
      while (got < 12) begin
        queue_random_fill(n);
        got = got + n;
      end
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && exp_pixels.size() == 0) begin
      $display("rect_fill_pixel_pack_core verification clean");
    end else begin
      $display("rect_fill_pixel_pack_core verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rect_fill_pixel_pack_core verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/rfpp_pkg.sv
hw/rtl/rfpp_pack.sv
hw/rtl/rect_fill_pixel_pack_core.sv
hw/rtl/rfpp_checker.sv
dv/tb.sv
